// ----- sv/baq_pkg.sv -----
// Shared widths, operation codes and sequencer states for the age queue.
`timescale 1ns / 1ps
`default_nettype none
package baq_pkg;

  localparam int AGE_W   = 8;
  localparam int FUNC_W  = 2;
  localparam int LIMIT_W = 5;
  localparam int POS_W   = 4;
  localparam int OCC_W   = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd10;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH_BACK  = 2'd0,
    FUNC_PUSH_FRONT = 2'd1,
    FUNC_POP_FRONT  = 2'd2,
    FUNC_SEARCH     = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_SCAN = 3'b100
  } state_t;

endpackage
`default_nettype wire

// ----- sv/bounded_age_queue_with_search.sv -----
// Top level: bounded age queue with push back/front, pop and linear search.
//
//  channel | signals                                   | dir | notes
//  --------+-------------------------------------------+-----+---------------------------
//  in      | in_valid, in_ready, func, age             | in  | one op per item
//  out     | out_valid, out_ready, ok, value, position,| out | one result per item,
//          | is_empty, occupancy                       |     | held in an output register
//  cfg     | cfg_wr_en, cfg_wr_data                    | in  | insert_limit, no wait
//
// Push and pop are accepted, then committed. A search compares entries from
// the head up to the first match or the end of the queue; the single ring read
// port and one 8-bit comparator visit one entry per cycle.
// in_ready is high only while the sequencer is idle; one item is in work at a time.
// A finished item waits in its last state while the output register still holds an
// untaken result; the next item is accepted even while a result waits.
// Reset (rst, synchronous): queue empty, lifetime insertion count zero, limit 10.
// The ring store itself is not cleared; only queued entries are ever read.
`timescale 1ns / 1ps
`default_nettype none
module bounded_age_queue_with_search #(
  parameter int CAPACITY = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [baq_pkg::FUNC_W-1:0]    func,
  input  wire logic [baq_pkg::AGE_W-1:0]     age,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               ok,
  output logic      [baq_pkg::AGE_W-1:0]     value,
  output logic      [baq_pkg::POS_W-1:0]     position,
  output logic                               is_empty,
  output logic      [baq_pkg::OCC_W-1:0]     occupancy,
  // configuration
  input  wire logic                          cfg_wr_en,
  input  wire logic [baq_pkg::LIMIT_W-1:0]   cfg_wr_data
);
  import baq_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

  function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] p);
    return (p == LAST_IDX) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] wrap_prev(input logic [IDX_W-1:0] p);
    return (p == '0) ? LAST_IDX : p - 1'b1;
  endfunction

  // control state
  state_t             state, state_next;
  logic [IDX_W-1:0]   head, head_next;
  logic [IDX_W-1:0]   tail, tail_next;
  logic [CNT_W-1:0]   entry_count, entry_count_next;
  logic [LIMIT_W-1:0] insertions_done, insertions_done_next;
  logic [LIMIT_W-1:0] insert_limit;

  // item under work
  func_t              op_func;
  logic [AGE_W-1:0]   op_age;
  logic [IDX_W-1:0]   scan_ptr, scan_ptr_next;
  logic [CNT_W-1:0]   scan_idx, scan_idx_next;

  // ring ports
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [IDX_W-1:0]   rd_addr;
  logic [AGE_W-1:0]   rd_data;

  // result into the output register
  logic               load_out;
  logic               res_ok;
  logic [AGE_W-1:0]   res_value;
  logic [CNT_W-1:0]   res_pos;

  logic in_fire;
  logic out_free;
  logic may_push;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign may_push = (insertions_done < insert_limit) && (entry_count != FULL_CNT);

  baq_ring #(
    .DEPTH(CAPACITY)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (op_age),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // sequencer: one commit per item, search walks one entry per cycle
  always_comb begin
    state_next           = state;
    head_next            = head;
    tail_next            = tail;
    entry_count_next     = entry_count;
    insertions_done_next = insertions_done;
    scan_ptr_next        = scan_ptr;
    scan_idx_next        = scan_idx;
    rd_addr              = head;
    wr_en                = 1'b0;
    wr_addr              = tail;
    load_out             = 1'b0;
    res_ok               = 1'b0;
    res_value            = '0;
    res_pos              = '0;

    unique case (state)
      S_IDLE: begin
        rd_addr = head;
        if (in_fire) begin
          scan_ptr_next = head;
          scan_idx_next = '0;
          state_next    = (func_t'(func) == FUNC_SEARCH) ? S_SCAN : S_EXEC;
        end
      end

      S_EXEC: begin
        rd_addr = head;  // keeps the head entry on rd_data for a pop
        if (out_free) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
          case (op_func)
            FUNC_PUSH_BACK: begin
              if (may_push) begin
                wr_en                = 1'b1;
                wr_addr              = tail;
                tail_next            = wrap_next(tail);
                entry_count_next     = entry_count + 1'b1;
                insertions_done_next = insertions_done + 1'b1;
                res_ok               = 1'b1;
              end
            end
            FUNC_PUSH_FRONT: begin
              if (may_push) begin
                wr_en                = 1'b1;
                wr_addr              = wrap_prev(head);
                head_next            = wrap_prev(head);
                entry_count_next     = entry_count + 1'b1;
                insertions_done_next = insertions_done + 1'b1;
                res_ok               = 1'b1;
              end
            end
            FUNC_POP_FRONT: begin
              if (entry_count != '0) begin
                head_next        = wrap_next(head);
                entry_count_next = entry_count - 1'b1;
                res_ok           = 1'b1;
                res_value        = rd_data;
              end
            end
            default: begin
              // search never lands here
            end
          endcase
        end
      end

      S_SCAN: begin
        rd_addr = scan_ptr;
        if (scan_idx == entry_count) begin
          // walked past the back: no match
          if (out_free) begin
            load_out   = 1'b1;
            state_next = S_IDLE;
          end
        end else if (rd_data == op_age) begin
          if (out_free) begin
            load_out   = 1'b1;
            res_ok     = 1'b1;
            res_value  = op_age;
            res_pos    = scan_idx;
            state_next = S_IDLE;
          end
        end else begin
          rd_addr       = wrap_next(scan_ptr);
          scan_ptr_next = wrap_next(scan_ptr);
          scan_idx_next = scan_idx + 1'b1;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      head            <= '0;
      tail            <= '0;
      entry_count     <= '0;
      insertions_done <= '0;
      insert_limit    <= LIMIT_RESET;
      out_valid       <= 1'b0;
    end else begin
      state           <= state_next;
      head            <= head_next;
      tail            <= tail_next;
      entry_count     <= entry_count_next;
      insertions_done <= insertions_done_next;
      if (cfg_wr_en) begin
        insert_limit <= cfg_wr_data;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    scan_ptr <= scan_ptr_next;
    scan_idx <= scan_idx_next;
    if (in_fire) begin
      op_func <= func_t'(func);
      op_age  <= age;
    end
    if (load_out) begin
      ok        <= res_ok;
      value     <= res_value;
      position  <= POS_W'(res_pos);
      is_empty  <= (entry_count_next == '0);
      occupancy <= OCC_W'(entry_count_next);
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= FULL_CNT)
    else $error("entry count above capacity");

  a_ptr_meet: assert property (@(posedge clk) disable iff (rst)
    (entry_count == '0 || entry_count == FULL_CNT) |-> head == tail)
    else $error("head and tail disagree with an empty or full queue");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("sequencer took no time over an accepted item");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> scan_idx <= entry_count)
    else $error("search walked past the back of the queue");

  a_load_needs_room: assert property (@(posedge clk) disable iff (rst)
    load_out |-> out_free)
    else $error("result loaded over an untaken result");

endmodule
`default_nettype wire

// ----- sv/baq_ring.sv -----
// Ring store of ages: one write port, one read port with registered data.
`timescale 1ns / 1ps
`default_nettype none
module baq_ring #(
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]               wr_addr,
  input  wire logic [baq_pkg::AGE_W-1:0]              wr_data,
  input  wire logic [$clog2(DEPTH)-1:0]               rd_addr,
  output logic      [baq_pkg::AGE_W-1:0]              rd_data
);
  import baq_pkg::*;

  logic [AGE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read-before-write: a read of a slot in its write cycle returns the old value
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire
